// ===== hdl/pat_pkg.sv =====
package pat_pkg;

   // Table and datapath sizing
   localparam int TABLE_PAGES = 16;
   localparam int FRAME_BITS  = 8;
   localparam int ADDR_BITS   = 16;

   // Fixed port widths
   localparam int MAP_PAGE_W  = 4;
   localparam int MAP_FRAME_W = 8;
   localparam int LADDR_W     = 16;
   localparam int PSIZE_W     = 16;
   localparam int PHYS_W      = 24;
   localparam int PNUM_W      = 16;
   localparam int POFF_W      = 16;

   localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = PSIZE_W'(1);

   // Derived widths
   localparam int PAGE_IDX_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int REM_W      = ((ADDR_BITS > PSIZE_W) ? ADDR_BITS : PSIZE_W) + 1;
   localparam int DIV_CNT_W  = $clog2(ADDR_BITS);
   localparam int PROD_W     = FRAME_BITS + PSIZE_W + 1;

   // Input item function codes
   localparam logic FUNC_MAP       = 1'b0;
   localparam logic FUNC_TRANSLATE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_MULTIPLY,
      ST_RESPOND
   } pat_state_type;

   // Table write request
   typedef struct packed {
      logic                  en;
      logic [PAGE_IDX_W-1:0] idx;
      logic [FRAME_BITS-1:0] frame;
      logic                  mapped;
   } pat_map_wr_type;

endpackage

// ===== hdl/paged_address_translator_core.sv =====
// Single-level page table translator with an arbitrary (non power of two)
// page size set through csr_wr_en / csr_wr_data (reset value 1; write only
// while idle). A map beat (req_func = 0) writes one table entry in the cycle
// it is accepted and returns nothing; pages beyond the table are ignored.
// A translate beat (req_func = 1) divides the address by the page size in a
// restoring radix-2 divider, one quotient bit per cycle, then looks up the
// page and forms frame * page_size + offset. A translate beat passes
// through a start step, the divider iterations, lookup, multiply and the
// response load, which waits until the output register is free or
// draining. req_ready is low from the translate beat until its response is
// loaded into the output register; a map beat leaves req_ready high.
// Unmapped or out-of-range pages, and a zero page size, give rsp_fault = 1
// with rsp_physical_address = 0; page number and offset are still reported
// (zero page size: all-ones page number, offset = address).
module paged_address_translator_core
   import pat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // Page size register
   input  logic                   csr_wr_en,
   input  logic [PSIZE_W-1:0]     csr_wr_data,

   // Request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [MAP_PAGE_W-1:0]  req_map_page,
   input  logic [MAP_FRAME_W-1:0] req_map_frame,
   input  logic                   req_map_valid,
   input  logic [LADDR_W-1:0]     req_logical_address,

   // Response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PHYS_W-1:0]      rsp_physical_address,
   output logic [PNUM_W-1:0]      rsp_page_number,
   output logic [POFF_W-1:0]      rsp_page_offset,
   output logic                   rsp_fault
);

   pat_state_type state_ff, state_in;

   logic [PSIZE_W-1:0] page_size_ff;

   // Request accept
   logic req_beat;
   assign req_beat = req_valid & req_ready;

   // Table write on an accepted map beat
   pat_map_wr_type map_wr;
   always_comb begin
      map_wr.en     = req_beat && (req_func == FUNC_MAP) &&
                      (32'(req_map_page) < TABLE_PAGES);
      map_wr.idx    = PAGE_IDX_W'(req_map_page);
      map_wr.frame  = FRAME_BITS'(req_map_frame);
      map_wr.mapped = req_map_valid;
   end

   // Page number and offset divider
   logic                 div_start;
   logic                 div_done;
   logic [ADDR_BITS-1:0] div_quot;
   logic [REM_W-1:0]     div_rem;

   pat_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (ADDR_BITS'(req_logical_address)),
      .divisor   (page_size_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Page table
   logic [FRAME_BITS-1:0] tbl_frame;
   logic                  tbl_mapped;

   pat_table u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (map_wr),
      .rd_idx    (PAGE_IDX_W'(div_quot)),
      .rd_frame  (tbl_frame),
      .rd_mapped (tbl_mapped)
   );

   // Working registers
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  hit_ff, hit_in;
   logic [PNUM_W-1:0]     pnum_ff, pnum_in;
   logic [POFF_W-1:0]     poff_ff, poff_in;
   logic [PHYS_W-1:0]     phys_ff, phys_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PHYS_W-1:0]     rsp_phys_ff, rsp_phys_in;
   logic [PNUM_W-1:0]     rsp_pnum_ff, rsp_pnum_in;
   logic [POFF_W-1:0]     rsp_poff_ff, rsp_poff_in;
   logic                  rsp_fault_ff, rsp_fault_in;

   logic              in_range;
   logic [PROD_W-1:0] product;

   assign in_range = (33'(div_quot) < 33'(TABLE_PAGES));
   assign product  = PROD_W'(frame_ff) * PROD_W'(page_size_ff) + PROD_W'(poff_ff);

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      frame_in     = frame_ff;
      hit_in       = hit_ff;
      pnum_in      = pnum_ff;
      poff_in      = poff_ff;
      phys_in      = phys_ff;
      rsp_phys_in  = rsp_phys_ff;
      rsp_pnum_in  = rsp_pnum_ff;
      rsp_poff_in  = rsp_poff_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_func == FUNC_TRANSLATE)) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Zero page size always faults (quotient is all ones).
            frame_in = tbl_frame;
            hit_in   = (page_size_ff != '0) && in_range && tbl_mapped;
            pnum_in  = PNUM_W'(div_quot);
            poff_in  = POFF_W'(div_rem);
            state_in = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            phys_in  = hit_ff ? PHYS_W'(product) : '0;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            // Load once the output register is free or draining.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_phys_in  = phys_ff;
               rsp_pnum_in  = pnum_ff;
               rsp_poff_in  = poff_ff;
               rsp_fault_in = ~hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_size_ff <= PAGE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            page_size_ff <= csr_wr_data;
         end
      end
      frame_ff     <= frame_in;
      hit_ff       <= hit_in;
      pnum_ff      <= pnum_in;
      poff_ff      <= poff_in;
      phys_ff      <= phys_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_pnum_ff  <= rsp_pnum_in;
      rsp_poff_ff  <= rsp_poff_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_page_number      = rsp_pnum_ff;
   assign rsp_page_offset      = rsp_poff_ff;
   assign rsp_fault            = rsp_fault_ff;

endmodule

// ===== hdl/pat_divider.sv =====
module pat_divider
   import pat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ADDR_BITS-1:0] dividend,
   input  logic [PSIZE_W-1:0]   divisor,
   output logic                 done,
   output logic [ADDR_BITS-1:0] quotient,
   output logic [REM_W-1:0]     remainder
);

   // Restoring radix-2 divider, one quotient bit per cycle.
   // A zero divisor yields all-ones quotient and remainder = dividend.
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] quot_ff, quot_in;
   logic [REM_W-1:0]     rem_ff, rem_in;

   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] divisor_ext;
   logic [REM_W-1:0] diff;
   logic             ge;

   assign divisor_ext = REM_W'(divisor);
   assign rem_shift   = {rem_ff[REM_W-2:0], quot_ff[ADDR_BITS-1]};
   assign ge          = (rem_shift >= divisor_ext);
   assign diff        = rem_shift - divisor_ext;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = DIV_CNT_W'(ADDR_BITS - 1);
         quot_in   = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         quot_in = {quot_ff[ADDR_BITS-2:0], ge};
         rem_in  = ge ? diff : rem_shift;
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/pat_table.sv =====
module pat_table
   import pat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  pat_map_wr_type        wr,
   input  logic [PAGE_IDX_W-1:0] rd_idx,
   output logic [FRAME_BITS-1:0] rd_frame,
   output logic                  rd_mapped
);

   // Mapped flags clear on reset; frame of an unmapped entry is never used.
   logic [FRAME_BITS-1:0]  frame_ff [TABLE_PAGES];
   logic [TABLE_PAGES-1:0] mapped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= '0;
      end else if (wr.en) begin
         mapped_ff[wr.idx] <= wr.mapped;
      end
      if (wr.en) begin
         frame_ff[wr.idx] <= wr.frame;
      end
   end

   assign rd_frame  = frame_ff[rd_idx];
   assign rd_mapped = mapped_ff[rd_idx];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import pat_pkg::*;

   // Cycles between acceptance of a translate and its response, with margin.
   // Used before page size writes and at the end of the run.
   localparam int SETTLE_CYCLES = ADDR_BITS + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int ADDR_MAX      = (1 << LADDR_W) - 1;
   localparam int PSIZE_MAX     = (1 << PSIZE_W) - 1;

   typedef struct {
      logic                   func;
      logic [MAP_PAGE_W-1:0]  page;
      logic [MAP_FRAME_W-1:0] frame;
      logic                   mapped;
      logic [LADDR_W-1:0]     addr;
   } request_beat_type;

   typedef struct {
      logic [PHYS_W-1:0] phys;
      logic [PNUM_W-1:0] pnum;
      logic [POFF_W-1:0] poff;
      logic              fault;
   } translation_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [PSIZE_W-1:0]     csr_wr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_func;
   logic [MAP_PAGE_W-1:0]  req_map_page;
   logic [MAP_FRAME_W-1:0] req_map_frame;
   logic                   req_map_valid;
   logic [LADDR_W-1:0]     req_logical_address;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [PHYS_W-1:0]      rsp_physical_address;
   logic [PNUM_W-1:0]      rsp_page_number;
   logic [POFF_W-1:0]      rsp_page_offset;
   logic                   rsp_fault;

   // Shadow copy of the block: page size register and the page table.
   logic [PSIZE_W-1:0]    page_size_shadow;
   logic [FRAME_BITS-1:0] shadow_frames [TABLE_PAGES];
   logic                  shadow_mapped [TABLE_PAGES];

   // Translations still owed by the block, oldest first.
   translation_type expected_translations [$];

   int mismatch_count;
   int cycle_count;
   int req_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_cycles;

   paged_address_translator_core uut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_map_page         (req_map_page),
      .req_map_frame        (req_map_frame),
      .req_map_valid        (req_map_valid),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_number      (rsp_page_number),
      .rsp_page_offset      (rsp_page_offset),
      .rsp_fault            (rsp_fault)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response side: random ready, or a counted hold-off when one is requested.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Response checker: every accepted beat is matched against the oldest
   // outstanding translation, field by field.
   always @(posedge clock) begin
      translation_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_translations.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %h %h %h %b",
                     $time, rsp_physical_address, rsp_page_number, rsp_page_offset,
                     rsp_fault);
         end else begin
            want = expected_translations.pop_front();
            if (rsp_physical_address !== want.phys) begin
               mismatch_count++;
               $display("%0t: physical_address expected %h actual %h",
                        $time, want.phys, rsp_physical_address);
            end
            if (rsp_page_number !== want.pnum) begin
               mismatch_count++;
               $display("%0t: page_number expected %h actual %h",
                        $time, want.pnum, rsp_page_number);
            end
            if (rsp_page_offset !== want.poff) begin
               mismatch_count++;
               $display("%0t: page_offset expected %h actual %h",
                        $time, want.poff, rsp_page_offset);
            end
            if (rsp_fault !== want.fault) begin
               mismatch_count++;
               $display("%0t: fault expected %b actual %b", $time, want.fault, rsp_fault);
            end
         end
      end
   end

   function automatic request_beat_type pack_request(logic func, int unsigned page,
                                                     int unsigned frame, logic mapped,
                                                     int unsigned addr);
      request_beat_type b;
      b.func   = func;
      b.page   = MAP_PAGE_W'(page);
      b.frame  = MAP_FRAME_W'(frame);
      b.mapped = mapped;
      b.addr   = LADDR_W'(addr);
      return b;
   endfunction

   function automatic request_beat_type make_map();
      return pack_request(FUNC_MAP, $urandom, $urandom,
                          $urandom_range(0, 99) < 80, $urandom);
   endfunction

   // Aimed translates land on a page inside (or just past) the table at the
   // current page size; the rest use a fully random address.
   function automatic request_beat_type make_translate(bit aimed);
      request_beat_type b;
      int unsigned      ps;
      int unsigned      top;
      int unsigned      page;
      int unsigned      off;
      int unsigned      base;
      b  = pack_request(FUNC_TRANSLATE, $urandom, $urandom, 1'($urandom), $urandom);
      ps = page_size_shadow;
      if (aimed && ps != 0) begin
         top = ADDR_MAX / ps;
         if (top > TABLE_PAGES)
            top = TABLE_PAGES;
         page = $urandom_range(0, top);
         base = page * ps;
         off  = $urandom_range(0, ps - 1);
         if (base + off > ADDR_MAX)
            off = ADDR_MAX - base;
         b.addr = LADDR_W'(base + off);
      end
      return b;
   endfunction

   // Offer one beat, hold it until accepted, then update the shadow table
   // or queue the expected translation. Valid is left high on return.
   task automatic send_beat(request_beat_type b);
      translation_type t;
      int unsigned     ps;
      int unsigned     quot;
      int unsigned     rem;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= b.func;
      req_map_page        <= b.page;
      req_map_frame       <= b.frame;
      req_map_valid       <= b.mapped;
      req_logical_address <= b.addr;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);

      if (b.func == FUNC_MAP) begin
         if (b.page < TABLE_PAGES) begin
            shadow_frames[b.page] = FRAME_BITS'(b.frame);
            shadow_mapped[b.page] = b.mapped;
         end
      end else begin
         ps = page_size_shadow;
         // Zero page size: divider gives all-ones quotient, remainder = address.
         if (ps == 0) begin
            quot = PNUM_W'(-1);
            rem  = b.addr;
         end else begin
            quot = b.addr / ps;
            rem  = b.addr % ps;
         end
         t.fault = 1'b1;
         t.phys  = '0;
         if (ps != 0 && quot < TABLE_PAGES && shadow_mapped[quot]) begin
            t.fault = 1'b0;
            t.phys  = PHYS_W'(shadow_frames[quot] * ps + rem);
         end
         t.pnum = PNUM_W'(quot);
         t.poff = POFF_W'(rem);
         expected_translations.push_back(t);
      end
   endtask

   // Sender stops offering until every outstanding translation has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_translations.size() != 0)
         @(posedge clock);
   endtask

   // Page size only changes with the block idle: drained plus settle time.
   task automatic write_page_size(logic [PSIZE_W-1:0] value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      page_size_shadow  = value;
   endtask

   // Reset state: page size 1, every page unmapped, so all translates fault.
   task automatic test_reset_state();
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, TABLE_PAGES - 1));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, TABLE_PAGES));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, ADDR_MAX));
   endtask

   // Map, lookup and unmap at the reset page size, then map a new page.
   task automatic test_map_lookup();
      send_beat(pack_request(FUNC_MAP, 0, 'hFF, 1'b1, 0));
      send_beat(pack_request(FUNC_MAP, TABLE_PAGES - 1, 'hAA, 1'b1, ADDR_MAX));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, TABLE_PAGES - 1));
      send_beat(pack_request(FUNC_MAP, TABLE_PAGES - 1, 'h55, 1'b0, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, TABLE_PAGES - 1));
      send_beat(pack_request(FUNC_MAP, 7, 'h00, 1'b1, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 7));
   endtask

   // Zero page size: all-ones page number, offset = address, always a fault.
   task automatic test_zero_page_size();
      write_page_size('0);
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, ADDR_MAX));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 5));
   endtask

   // Largest page size with the largest frame: widest product.
   task automatic test_max_page_size();
      write_page_size(PSIZE_W'(PSIZE_MAX));
      send_beat(pack_request(FUNC_MAP, 0, 'hFF, 1'b1, 0));
      send_beat(pack_request(FUNC_MAP, 1, 'hFF, 1'b1, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, ADDR_MAX - 1));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, ADDR_MAX));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 0));
   endtask

   // Non power of two size: last page in the table, then first page past it.
   task automatic test_odd_page_size();
      write_page_size(PSIZE_W'(3));
      send_beat(pack_request(FUNC_MAP, TABLE_PAGES - 1, 'h10, 1'b1, 0));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 3 * TABLE_PAGES - 1));
      send_beat(pack_request(FUNC_TRANSLATE, 0, 0, 0, 3 * TABLE_PAGES));
   endtask

   // Mixed traffic: mostly aimed translates, a share of map beats to keep
   // the table changing, and some wild addresses.
   task automatic test_random_traffic(logic [PSIZE_W-1:0] size, int beats);
      int pick;
      write_page_size(size);
      repeat (beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            send_beat(make_map());
         else
            send_beat(make_translate(pick < 85));
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering,
   // so the output register fills and req_ready drops.
   task automatic test_output_backpressure();
      req_idle_pct    = 0;
      rsp_hold_cycles = 400;
      repeat (10) send_beat(make_translate(1'b1));
      req_idle_pct = 27;
   endtask

   // Sender pauses mid-stream until everything outstanding has returned.
   task automatic test_sender_pause();
      repeat (20) send_beat($urandom_range(0, 99) < 30 ? make_map() : make_translate(1'b1));
      wait_for_drain();
      repeat (20) send_beat($urandom_range(0, 99) < 30 ? make_map() : make_translate(1'b1));
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_valid           <= 1'b0;
      req_func            <= FUNC_MAP;
      req_map_page        <= '0;
      req_map_frame       <= '0;
      req_map_valid       <= 1'b0;
      req_logical_address <= '0;
      mismatch_count   = 0;
      req_idle_pct     = 27;
      rsp_idle_pct     = 27;
      rsp_hold_cycles  = 0;
      page_size_shadow = PAGE_SIZE_RESET;
      for (int i = 0; i < TABLE_PAGES; i++) begin
         shadow_frames[i] = '0;
         shadow_mapped[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_map_lookup();
      test_zero_page_size();
      test_max_page_size();
      test_odd_page_size();

      test_random_traffic(PSIZE_W'(1), 110);
      test_random_traffic(PSIZE_W'(7), 120);
      test_random_traffic(PSIZE_W'(100), 120);
      // Long stretch with both sides always ready.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(PSIZE_W'(4096), 100);
      req_idle_pct = 27;
      rsp_idle_pct = 27;
      test_random_traffic(PSIZE_W'(PSIZE_MAX), 100);
      test_random_traffic('0, 40);
      test_random_traffic(PSIZE_W'(3000), 110);
      test_random_traffic(PSIZE_W'($urandom_range(1, PSIZE_MAX)), 100);
      test_random_traffic(PSIZE_W'(2), 90);

      test_output_backpressure();
      test_sender_pause();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== paged_address_translator_core.f =====
hdl/pat_pkg.sv
hdl/pat_divider.sv
hdl/pat_table.sv
hdl/paged_address_translator_core.sv
tb/tb_top.sv
